// ----- design/nsdd_pkg.sv -----
// nsdd_pkg: shared constants, codes and item types of the null symbol dip detector
// no dependencies; imported by every module of the block

package nsdd_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAG_BITS   = 17;
  localparam int unsigned WINDOW_LEN = 50;
  localparam int unsigned LEVEL_FRAC = 24;
  localparam int unsigned RATIO_FRAC = 8;
  localparam int unsigned LEVEL_W    = MAG_BITS + LEVEL_FRAC;
  localparam int unsigned SUM_W      = 22;
  localparam int unsigned POS_W      = $clog2(WINDOW_LEN);
  localparam int unsigned CNT_W      = 18;
  localparam int unsigned ETO_W      = 16;
  localparam int unsigned RATIO_W    = 8;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned SCALE_W    = RATIO_W + $clog2(WINDOW_LEN + 1);
  localparam int unsigned PROD_W     = LEVEL_W + SCALE_W;
  localparam int unsigned CMP_SHIFT  = LEVEL_FRAC + RATIO_FRAC;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned IN_DATA_W  = 2 * SAMPLE_W;
  localparam int unsigned RES_BITS   = 3 + 3 + MAG_BITS + SUM_W;
  localparam int unsigned OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

  localparam int unsigned WARMUP_RST    = 98304;
  localparam int unsigned DIP_TO_RST    = 196608;
  localparam int unsigned END_TO_RST    = 2706;
  localparam int unsigned DIP_RATIO_RST = 128;
  localparam int unsigned END_RATIO_RST = 192;
  localparam int unsigned ALPHA_RST     = 17;

  typedef enum logic [2:0] {
    ST_WARMUP = 3'd0,
    ST_FILL   = 3'd1,
    ST_DIP    = 3'd2,
    ST_END    = 3'd3,
    ST_LOCKED = 3'd4
  } stage_e;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_DIP         = 3'd1,
    EV_NULL_END    = 3'd2,
    EV_DIP_TIMEOUT = 3'd3,
    EV_END_TIMEOUT = 3'd4
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARMUP    = 3'd0,
    CFG_DIP_TO    = 3'd1,
    CFG_END_TO    = 3'd2,
    CFG_DIP_RATIO = 3'd3,
    CFG_END_RATIO = 3'd4,
    CFG_ALPHA     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0]   warmup_length;
    logic [CNT_W-1:0]   dip_timeout;
    logic [ETO_W-1:0]   end_timeout;
    logic [SCALE_W-1:0] dip_scale;
    logic [SCALE_W-1:0] end_scale;
    logic [SHIFT_W-1:0] alpha_shift;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    warmup_length: CNT_W'(WARMUP_RST),
    dip_timeout:   CNT_W'(DIP_TO_RST),
    end_timeout:   ETO_W'(END_TO_RST),
    dip_scale:     SCALE_W'(WINDOW_LEN * DIP_RATIO_RST),
    end_scale:     SCALE_W'(WINDOW_LEN * END_RATIO_RST),
    alpha_shift:   SHIFT_W'(ALPHA_RST)
  };

  typedef struct packed {
    logic [MAG_BITS-1:0] mag;
    logic                restart;
    logic [LEVEL_W-1:0]  acc;
  } lvl_t;

  typedef struct packed {
    logic [MAG_BITS-1:0] mag;
    logic                restart;
    logic [MAG_BITS-1:0] long_level;
    logic [PROD_W-1:0]   dip_thr;
    logic [PROD_W-1:0]   end_thr;
  } thr_t;

  typedef struct packed {
    logic [SUM_W-1:0]    window_sum;
    logic [MAG_BITS-1:0] long_level;
    stage_e              stage;
    event_e              event_res;
  } res_t;

endpackage

// ----- design/nsdd_cfg_regs.sv -----
// nsdd_cfg_regs: configuration register file, ratios stored pre-scaled by the window length
// depends on nsdd_pkg

module nsdd_cfg_regs
  import nsdd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WARMUP:    cfg_d.warmup_length = cfg_data_i[CNT_W-1:0];
        CFG_DIP_TO:    cfg_d.dip_timeout   = cfg_data_i[CNT_W-1:0];
        CFG_END_TO:    cfg_d.end_timeout   = cfg_data_i[ETO_W-1:0];
        CFG_DIP_RATIO: cfg_d.dip_scale     = SCALE_W'(WINDOW_LEN * cfg_data_i[RATIO_W-1:0]);
        CFG_END_RATIO: cfg_d.end_scale     = SCALE_W'(WINDOW_LEN * cfg_data_i[RATIO_W-1:0]);
        CFG_ALPHA:     cfg_d.alpha_shift   = cfg_data_i[SHIFT_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- design/nsdd_level.sv -----
// nsdd_level: input register, l1 magnitude stage and long-term average stage
// depends on nsdd_pkg

module nsdd_level
  import nsdd_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] re_i,
  input  logic signed [SAMPLE_W-1:0] im_i,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lvl_t                       out_o
);

  function automatic logic [MAG_BITS-1:0] abs_mag(input logic signed [SAMPLE_W-1:0] v);
    logic [MAG_BITS-1:0] ext;
    ext = MAG_BITS'(v);
    return v[SAMPLE_W-1] ? (MAG_BITS'(0) - ext) : ext;
  endfunction

  logic                       v1_q, v2_q, v3_q;
  logic                       rdy1, rdy2, rdy3;
  logic signed [SAMPLE_W-1:0] re1_q, im1_q;
  logic                       restart1_q, restart2_q, restart3_q;
  logic [MAG_BITS-1:0]        mag2_q, mag3_q;
  logic [LEVEL_W-1:0]         acc_q, acc_d;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    acc_d = acc_q - (acc_q >> cfg_i.alpha_shift)
          + ((LEVEL_W'(mag2_q) << LEVEL_FRAC) >> cfg_i.alpha_shift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy3 && v2_q) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      re1_q      <= re_i;
      im1_q      <= im_i;
      restart1_q <= restart_i;
    end
    if (rdy2 && v1_q) begin
      mag2_q     <= abs_mag(re1_q) + abs_mag(im1_q);
      restart2_q <= restart1_q;
    end
    if (rdy3 && v2_q) begin
      mag3_q     <= mag2_q;
      restart3_q <= restart2_q;
    end
  end

  assign out_valid_o   = v3_q;
  assign out_o.mag     = mag3_q;
  assign out_o.restart = restart3_q;
  assign out_o.acc     = acc_q;

endmodule

// ----- design/nsdd_thresh.sv -----
// nsdd_thresh: scales the long-term level by the dip and null-end ratios
// depends on nsdd_pkg

module nsdd_thresh
  import nsdd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  lvl_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output thr_t out_o
);

  logic v_q;
  logic rdy;
  thr_t thr_q, thr_d;

  assign rdy        = !v_q || out_ready_i;
  assign in_ready_o = rdy;

  always_comb begin
    thr_d.mag        = in_i.mag;
    thr_d.restart    = in_i.restart;
    thr_d.long_level = in_i.acc[LEVEL_W-1:LEVEL_FRAC];
    thr_d.dip_thr    = PROD_W'(in_i.acc) * PROD_W'(cfg_i.dip_scale);
    thr_d.end_thr    = PROD_W'(in_i.acc) * PROD_W'(cfg_i.end_scale);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      thr_q <= thr_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_o       = thr_q;

endmodule

// ----- design/nsdd_tracker.sv -----
// nsdd_tracker: magnitude shift line, moving sum, stage sequencer and result register
// depends on nsdd_pkg

module nsdd_tracker
  import nsdd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  thr_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  logic                rdy, fire;
  stage_e              stage_q, stage_d, eff_stage;
  logic [CNT_W-1:0]    cnt_q, cnt_d, eff_cnt;
  logic [POS_W-1:0]    pos_q, pos_d, eff_pos;
  logic [SUM_W-1:0]    sum_q, sum_d, eff_sum;
  logic [MAG_BITS-1:0] win_q [WINDOW_LEN];
  logic                shift_en;
  logic                fill_start, fill_done, warm_done, dip_to, end_to;
  logic                below, above;
  logic [CNT_W:0]      cnt_inc;
  logic [SUM_W-1:0]    sum_fill, sum_slide, sum_cmp;
  logic [PROD_W-1:0]   sum_sh;
  event_e              ev;
  logic                ov_q;
  res_t                res_q, res_d;

  assign rdy        = !ov_q || out_ready_i;
  assign fire       = in_valid_i && rdy;
  assign in_ready_o = rdy;

  // terms shared by next state and event
  always_comb begin
    fill_start = in_i.restart || (stage_q == ST_WARMUP && cnt_q >= cfg_i.warmup_length);
    eff_stage  = fill_start ? ST_FILL : stage_q;
    eff_cnt    = fill_start ? '0 : cnt_q;
    eff_pos    = fill_start ? '0 : pos_q;
    eff_sum    = fill_start ? '0 : sum_q;
    cnt_inc    = {1'b0, eff_cnt} + (CNT_W+1)'(1);
    warm_done  = cnt_inc >= {1'b0, cfg_i.warmup_length};
    fill_done  = eff_pos == POS_W'(WINDOW_LEN - 1);
    dip_to     = eff_cnt >= cfg_i.dip_timeout;
    end_to     = eff_cnt >= CNT_W'(cfg_i.end_timeout);
    sum_fill   = eff_sum + SUM_W'(in_i.mag);
    sum_slide  = eff_sum + SUM_W'(in_i.mag) - SUM_W'(win_q[WINDOW_LEN-1]);
    sum_cmp    = (eff_stage == ST_FILL) ? sum_fill : sum_slide;
    sum_sh     = PROD_W'(sum_cmp) << CMP_SHIFT;
    below      = sum_sh <= in_i.dip_thr;
    above      = sum_sh >= in_i.end_thr;
  end

  // next state
  always_comb begin
    stage_d  = stage_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    shift_en = 1'b0;
    if (fire) begin
      stage_d  = eff_stage;
      cnt_d    = eff_cnt;
      pos_d    = eff_pos;
      sum_d    = eff_sum;
      shift_en = eff_stage != ST_WARMUP;
      case (eff_stage)
        ST_WARMUP: begin
          if (warm_done) begin
            stage_d = ST_FILL;
            cnt_d   = '0;
            pos_d   = '0;
            sum_d   = '0;
          end else begin
            cnt_d = cnt_inc[CNT_W-1:0];
          end
        end
        ST_FILL: begin
          sum_d = sum_fill;
          if (fill_done) begin
            pos_d   = '0;
            cnt_d   = '0;
            stage_d = below ? (above ? ST_LOCKED : ST_END) : ST_DIP;
          end else begin
            pos_d = eff_pos + POS_W'(1);
          end
        end
        ST_DIP: begin
          if (dip_to) begin
            stage_d = ST_FILL;
            cnt_d   = '0;
            pos_d   = '0;
            sum_d   = '0;
          end else begin
            sum_d = sum_slide;
            cnt_d = cnt_inc[CNT_W-1:0];
            if (below) begin
              stage_d = above ? ST_LOCKED : ST_END;
              cnt_d   = '0;
            end
          end
        end
        ST_END: begin
          if (end_to) begin
            stage_d = ST_FILL;
            cnt_d   = '0;
            pos_d   = '0;
            sum_d   = '0;
          end else begin
            sum_d = sum_slide;
            cnt_d = cnt_inc[CNT_W-1:0];
            if (above) begin
              stage_d = ST_LOCKED;
            end
          end
        end
        default: begin
          stage_d = ST_LOCKED;
          sum_d   = sum_slide;
        end
      endcase
    end
  end

  // event of this item
  always_comb begin
    ev = EV_NONE;
    case (eff_stage)
      ST_FILL: begin
        if (fill_done && below) begin
          ev = above ? EV_NULL_END : EV_DIP;
        end
      end
      ST_DIP: begin
        if (dip_to) begin
          ev = EV_DIP_TIMEOUT;
        end else if (below) begin
          ev = above ? EV_NULL_END : EV_DIP;
        end
      end
      ST_END: begin
        if (end_to) begin
          ev = EV_END_TIMEOUT;
        end else if (above) begin
          ev = EV_NULL_END;
        end
      end
      default: ev = EV_NONE;
    endcase
  end

  always_comb begin
    res_d.event_res  = ev;
    res_d.stage      = stage_d;
    res_d.long_level = in_i.long_level;
    res_d.window_sum = sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_WARMUP;
      cnt_q   <= '0;
      pos_q   <= '0;
      sum_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      stage_q <= stage_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      if (rdy) begin
        ov_q <= in_valid_i;
      end
    end
  end

  // oldest magnitude sits at the last tap
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      win_q[0] <= in_i.mag;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_o       = res_q;

endmodule

// ----- design/null_symbol_dip_detector.sv -----
// null_symbol_dip_detector: top level, one result item per sample item
// path: an accepted item passes the input, magnitude and level registers, then the threshold and result registers
// throughput: one item per clock unless m_axis_tready stalls the output; the moving-sum and stage update sets the loop
// reset: rst_ni clears pipeline valids, long-term level, moving sum, counters and
// stage (to warm-up) and restores register defaults; magnitude taps are not cleared
// depends on nsdd_pkg, nsdd_cfg_regs, nsdd_level, nsdd_thresh, nsdd_tracker

module null_symbol_dip_detector
  import nsdd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample_re, sample_im
  input  logic                  s_axis_tuser,   // restart
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // event_res, stage, long_level, window_sum
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg;
  lvl_t lvl;
  thr_t thr;
  res_t res;
  logic lvl_valid, lvl_ready, thr_valid, thr_ready;

  nsdd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  nsdd_level u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .re_i        (s_axis_tdata[SAMPLE_W-1:0]),
    .im_i        (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .restart_i   (s_axis_tuser),
    .out_valid_o (lvl_valid),
    .out_ready_i (lvl_ready),
    .out_o       (lvl)
  );

  nsdd_thresh u_thresh (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (lvl_valid),
    .in_ready_o  (lvl_ready),
    .in_i        (lvl),
    .out_valid_o (thr_valid),
    .out_ready_i (thr_ready),
    .out_o       (thr)
  );

  nsdd_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (thr_valid),
    .in_ready_o  (thr_ready),
    .in_i        (thr),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = OUT_DATA_W'(res);

`ifndef SYNTHESIS
  a_dip_enters_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.event_res == EV_DIP |-> res.stage == ST_END)
    else $error("dip event without end search stage");

  a_null_end_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.event_res == EV_NULL_END |-> res.stage == ST_LOCKED)
    else $error("null end event without lock");

  a_timeout_refills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.event_res == EV_DIP_TIMEOUT || res.event_res == EV_END_TIMEOUT)
    |-> res.stage == ST_FILL && res.window_sum == '0)
    else $error("timeout did not restart the window fill");

  a_stall_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with no result waiting");
`endif

endmodule
